FILE: rtl/prefix_code_trie_decoder_top_macros.svh
// Assertion macros used by the trie decoder datapath
`ifndef PREFIX_CODE_TRIE_DECODER_TOP_MACROS_SVH
`define PREFIX_CODE_TRIE_DECODER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define PCTD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PCTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pctd_pkg.sv
// Package: codes, widths and command/status types of the prefix code trie decoder
`default_nettype none

package pctd_pkg;

    localparam int DEF_NODE_DEPTH = 512;
    localparam int MAX_CODE_LEN   = 32;

    localparam int SYM_W     = 8;
    localparam int CODE_W    = 32;
    localparam int LEN_W     = 6;
    localparam int LVL_W     = 5;
    localparam int COUNT_W   = 16;
    localparam int LIMIT_W   = 17;
    localparam int STATUS_W  = 3;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_ADD    = 2'd1,
        OP_DECODE = 2'd2,
        OP_START  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_BAD_LEN = 3'd1,
        ST_FULL    = 3'd2,
        ST_INVALID = 3'd3,
        ST_LIMIT   = 3'd4
    } status_t;

    localparam logic [PADDR_W-1:0] REG_RUN_LIMIT = 3'd0;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_ACCEPT,
        CMD_CLEAR,
        CMD_START,
        CMD_DECODE,
        CMD_BAD_LEN,
        CMD_ADD_INIT,
        CMD_ADD_READ,
        CMD_ADD_LOAD,
        CMD_ADD_MAKE,
        CMD_ADD_LINK,
        CMD_ADD_FULL,
        CMD_ADD_OK
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic len_bad;
        logic walk_last;
        logic walk_child_zero;
        logic store_full;
        logic slot_free;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/pctd_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module pctd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pctd_ctrl.sv
// Controller state machine: sequences accept, clear, start, add walk, decode and result hand-off
`default_nettype none

module pctd_ctrl
    import pctd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire logic     in_ready_unused_guard,
    input  wire logic [1:0] operation,
    input  wire dp_stat_t stat,
    output logic          in_ready,
    output cmd_t          cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DEC,
        S_ADD_STEP,
        S_ADD_LOAD,
        S_ADD_LINK,
        S_ADD_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE) && in_ready_unused_guard;

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd = CMD_ACCEPT;
                    if (op_t'(operation) == OP_DECODE)
                    begin
                        state_next = S_DEC;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                unique case (stat.op)
                    OP_CLEAR:
                    begin
                        if (stat.slot_free)
                        begin
                            cmd        = CMD_CLEAR;
                            state_next = S_IDLE;
                        end
                    end
                    OP_START:
                    begin
                        if (stat.slot_free)
                        begin
                            cmd        = CMD_START;
                            state_next = S_IDLE;
                        end
                    end
                    OP_ADD:
                    begin
                        if (stat.len_bad)
                        begin
                            if (stat.slot_free)
                            begin
                                cmd        = CMD_BAD_LEN;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd        = CMD_ADD_INIT;
                            state_next = S_ADD_STEP;
                        end
                    end
                    default:
                    begin
                        // decode items go straight to S_DEC
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_DEC:
            begin
                if (stat.slot_free)
                begin
                    cmd        = CMD_DECODE;
                    state_next = S_IDLE;
                end
            end
            S_ADD_STEP:
            begin
                if (stat.walk_last || stat.walk_child_zero)
                begin
                    if (stat.store_full)
                    begin
                        if (stat.slot_free)
                        begin
                            cmd        = CMD_ADD_FULL;
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        cmd        = CMD_ADD_MAKE;
                        state_next = S_ADD_LINK;
                    end
                end
                else
                begin
                    cmd        = CMD_ADD_READ;
                    state_next = S_ADD_LOAD;
                end
            end
            S_ADD_LOAD:
            begin
                cmd        = CMD_ADD_LOAD;
                state_next = S_ADD_STEP;
            end
            S_ADD_LINK:
            begin
                cmd = CMD_ADD_LINK;
                if (stat.walk_last)
                begin
                    state_next = S_ADD_DONE;
                end
                else
                begin
                    state_next = S_ADD_STEP;
                end
            end
            S_ADD_DONE:
            begin
                if (stat.slot_free)
                begin
                    cmd        = CMD_ADD_OK;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pctd_dp.sv
// Datapath: node store, root and cursor registers, add walk, limit register, result register
`default_nettype none

`include "prefix_code_trie_decoder_top_macros.svh"

module pctd_dp
    import pctd_pkg::*;
#(
    parameter int NODE_DEPTH = DEF_NODE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cmd_t                cmd,
    output dp_stat_t                 stat,
    // item fields
    input  wire logic [1:0]          operation,
    input  wire logic [SYM_W-1:0]    symbol,
    input  wire logic [CODE_W-1:0]   code_bits,
    input  wire logic [LEN_W-1:0]    code_length,
    input  wire logic                bit_in,
    // result
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [SYM_W-1:0]         symbol_out,
    output logic                     symbol_valid,
    output logic [STATUS_W-1:0]      status,
    output logic [COUNT_W-1:0]       decoded_count,
    // configuration
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]       prdata
);

    localparam int IDX_W = $clog2(NODE_DEPTH);
    localparam int CNT_W = $clog2(NODE_DEPTH + 1);
    localparam int ENT_W = 2 * IDX_W + SYM_W;

    // entry layout: {left, right, symbol}
    localparam int L_LO = IDX_W + SYM_W;
    localparam int R_LO = SYM_W;

    // latched item
    op_t                op_reg;
    logic [SYM_W-1:0]   sym_reg;
    logic [CODE_W-1:0]  code_reg;
    logic [LEN_W-1:0]   len_reg;

    logic [LIMIT_W-1:0] limit_reg;
    logic [CNT_W-1:0]   nodes_used_reg;
    logic [CNT_W-1:0]   nodes_used_next;
    logic [IDX_W-1:0]   root_left_reg,  root_left_next;
    logic [IDX_W-1:0]   root_right_reg, root_right_next;
    logic [IDX_W-1:0]   cursor_reg,     cursor_next;
    logic [IDX_W-1:0]   cur_left_reg,   cur_left_next;
    logic [IDX_W-1:0]   cur_right_reg,  cur_right_next;
    logic [COUNT_W-1:0] run_count_reg,  run_count_next;
    logic [IDX_W-1:0]   dec_child_reg;

    // add walk
    logic [IDX_W-1:0]   wn_idx_reg,   wn_idx_next;
    logic [IDX_W-1:0]   wn_left_reg,  wn_left_next;
    logic [IDX_W-1:0]   wn_right_reg, wn_right_next;
    logic [SYM_W-1:0]   wn_sym_reg,   wn_sym_next;
    logic [LVL_W-1:0]   lvl_reg,      lvl_next;
    logic [IDX_W-1:0]   new_idx_reg;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]   symbol_out_reg, symbol_out_next;
    logic               symbol_valid_reg, symbol_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    // node store port
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENT_W-1:0]   ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENT_W-1:0]   ram_rdata;

    logic               fin;
    logic               slot_free;
    logic               walk_bit;
    logic [IDX_W-1:0]   walk_child;
    logic [IDX_W-1:0]   node_left;
    logic [IDX_W-1:0]   node_right;
    logic [IDX_W-1:0]   port_child;
    logic [IDX_W-1:0]   new_idx;
    logic               store_full;
    logic               limited;
    logic [IDX_W-1:0]   rd_left;
    logic [IDX_W-1:0]   rd_right;
    logic [SYM_W-1:0]   rd_sym;
    logic               cfg_write;

    pctd_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NODE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_left  = ram_rdata[L_LO +: IDX_W];
    assign rd_right = ram_rdata[R_LO +: IDX_W];
    assign rd_sym   = ram_rdata[0 +: SYM_W];

    assign slot_free  = !out_valid_reg || out_ready;
    assign store_full = (nodes_used_reg == CNT_W'(NODE_DEPTH));
    assign new_idx    = nodes_used_reg[IDX_W-1:0];
    assign walk_bit   = code_reg[lvl_reg];
    assign walk_child = walk_bit ? wn_right_reg : wn_left_reg;

    // children of the node under the cursor; the root lives in flops
    assign node_left  = (cursor_reg == '0) ? root_left_reg  : cur_left_reg;
    assign node_right = (cursor_reg == '0) ? root_right_reg : cur_right_reg;
    assign port_child = bit_in  ? node_right : node_left;

    assign limited = (limit_reg != '1) &&
                     (limit_reg[LIMIT_W-1] || ({1'b0, run_count_reg} >= limit_reg));

    assign fin = (cmd == CMD_CLEAR) || (cmd == CMD_START) || (cmd == CMD_DECODE) ||
                 (cmd == CMD_BAD_LEN) || (cmd == CMD_ADD_FULL) || (cmd == CMD_ADD_OK);

    always_comb
    begin
        stat.op              = op_reg;
        stat.len_bad         = (len_reg == '0) || (len_reg > LEN_W'(MAX_CODE_LEN));
        stat.walk_last       = (lvl_reg == '0);
        stat.walk_child_zero = (walk_child == '0);
        stat.store_full      = store_full;
        stat.slot_free       = slot_free;
    end

    // node store access
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = new_idx;
        ram_wdata = {{IDX_W{1'b0}}, {IDX_W{1'b0}}, {SYM_W{1'b0}}};
        ram_re    = 1'b0;
        ram_raddr = walk_child;
        case (cmd)
            CMD_ACCEPT:
            begin
                ram_re    = (op_t'(operation) == OP_DECODE);
                ram_raddr = port_child;
            end
            CMD_ADD_READ:
            begin
                ram_re = 1'b1;
            end
            CMD_ADD_MAKE:
            begin
                ram_we    = 1'b1;
                ram_waddr = new_idx;
                ram_wdata = {{IDX_W{1'b0}}, {IDX_W{1'b0}},
                             (lvl_reg == '0) ? sym_reg : {SYM_W{1'b0}}};
            end
            CMD_ADD_LINK:
            begin
                ram_we    = (wn_idx_reg != '0);
                ram_waddr = wn_idx_reg;
                if (walk_bit)
                begin
                    ram_wdata = {wn_left_reg, new_idx_reg, wn_sym_reg};
                end
                else
                begin
                    ram_wdata = {new_idx_reg, wn_right_reg, wn_sym_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        nodes_used_next   = nodes_used_reg;
        root_left_next    = root_left_reg;
        root_right_next   = root_right_reg;
        cursor_next       = cursor_reg;
        cur_left_next     = cur_left_reg;
        cur_right_next    = cur_right_reg;
        run_count_next    = run_count_reg;
        wn_idx_next       = wn_idx_reg;
        wn_left_next      = wn_left_reg;
        wn_right_next     = wn_right_reg;
        wn_sym_next       = wn_sym_reg;
        lvl_next          = lvl_reg;
        symbol_out_next   = '0;
        symbol_valid_next = 1'b0;
        status_next       = ST_OK;

        // keep the cached cursor node in step with writes to it
        if (ram_we && (ram_waddr == cursor_reg) && (cursor_reg != '0))
        begin
            cur_left_next  = ram_wdata[L_LO +: IDX_W];
            cur_right_next = ram_wdata[R_LO +: IDX_W];
        end

        case (cmd)
            CMD_CLEAR:
            begin
                nodes_used_next = CNT_W'(1);
                root_left_next  = '0;
                root_right_next = '0;
                cursor_next     = '0;
            end
            CMD_START:
            begin
                run_count_next = '0;
                cursor_next    = '0;
            end
            CMD_BAD_LEN:
            begin
                status_next = ST_BAD_LEN;
            end
            CMD_ADD_FULL:
            begin
                status_next = ST_FULL;
            end
            CMD_DECODE:
            begin
                if (limited)
                begin
                    status_next = ST_LIMIT;
                end
                else if (dec_child_reg == '0)
                begin
                    status_next = ST_INVALID;
                    cursor_next = '0;
                end
                else if ((rd_left == '0) && (rd_right == '0))
                begin
                    symbol_out_next   = rd_sym;
                    symbol_valid_next = 1'b1;
                    cursor_next       = '0;
                    if (run_count_reg != '1)
                    begin
                        run_count_next = run_count_reg + COUNT_W'(1);
                    end
                end
                else
                begin
                    cursor_next    = dec_child_reg;
                    cur_left_next  = rd_left;
                    cur_right_next = rd_right;
                end
            end
            CMD_ADD_INIT:
            begin
                wn_idx_next   = '0;
                wn_left_next  = root_left_reg;
                wn_right_next = root_right_reg;
                wn_sym_next   = '0;
                lvl_next      = LVL_W'(len_reg - LEN_W'(1));
            end
            CMD_ADD_LOAD:
            begin
                wn_idx_next   = walk_child;
                wn_left_next  = rd_left;
                wn_right_next = rd_right;
                wn_sym_next   = rd_sym;
                lvl_next      = lvl_reg - LVL_W'(1);
            end
            CMD_ADD_MAKE:
            begin
                nodes_used_next = nodes_used_reg + CNT_W'(1);
            end
            CMD_ADD_LINK:
            begin
                if (wn_idx_reg == '0)
                begin
                    if (walk_bit)
                    begin
                        root_right_next = new_idx_reg;
                    end
                    else
                    begin
                        root_left_next = new_idx_reg;
                    end
                end
                wn_idx_next   = new_idx_reg;
                wn_left_next  = '0;
                wn_right_next = '0;
                wn_sym_next   = '0;
                if (lvl_reg != '0)
                begin
                    lvl_next = lvl_reg - LVL_W'(1);
                end
            end
            default:
            begin
            end
        endcase

        if (fin)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign cfg_write = psel && penable && pwrite && (paddr[PADDR_W-1:2] == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg      <= '1;
            nodes_used_reg <= CNT_W'(1);
            root_left_reg  <= '0;
            root_right_reg <= '0;
            cursor_reg     <= '0;
            run_count_reg  <= '0;
            out_valid_reg  <= 1'b0;
            lvl_reg        <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                limit_reg <= pwdata[LIMIT_W-1:0];
            end
            nodes_used_reg <= nodes_used_next;
            root_left_reg  <= root_left_next;
            root_right_reg <= root_right_next;
            cursor_reg     <= cursor_next;
            run_count_reg  <= run_count_next;
            out_valid_reg  <= out_valid_next;
            lvl_reg        <= lvl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd == CMD_ACCEPT)
        begin
            op_reg        <= op_t'(operation);
            sym_reg       <= symbol;
            code_reg      <= code_bits;
            len_reg       <= code_length;
            dec_child_reg <= port_child;
        end
        if (cmd == CMD_ADD_MAKE)
        begin
            new_idx_reg <= new_idx;
        end
        cur_left_reg  <= cur_left_next;
        cur_right_reg <= cur_right_next;
        wn_idx_reg    <= wn_idx_next;
        wn_left_reg   <= wn_left_next;
        wn_right_reg  <= wn_right_next;
        wn_sym_reg    <= wn_sym_next;
        if (fin)
        begin
            symbol_out_reg   <= symbol_out_next;
            symbol_valid_reg <= symbol_valid_next;
            status_reg       <= status_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign symbol_out    = symbol_out_reg;
    assign symbol_valid  = symbol_valid_reg;
    assign status        = status_reg;
    assign decoded_count = run_count_reg;

    always_comb
    begin
        if (paddr[PADDR_W-1:2] == REG_RUN_LIMIT[PADDR_W-1:2])
        begin
            prdata = {{(PDATA_W-LIMIT_W){limit_reg[LIMIT_W-1]}}, limit_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    `PCTD_ASSERT_NOW(a_nodes_low, 1'b1, nodes_used_reg != '0, "node count fell to zero")
    `PCTD_ASSERT_NOW(a_nodes_high, 1'b1, nodes_used_reg <= CNT_W'(NODE_DEPTH), "nodes past depth")
    `PCTD_ASSERT_NOW(a_cursor_made, 1'b1, {1'b0, cursor_reg} < nodes_used_reg, "cursor unmade")
    `PCTD_ASSERT_NOW(a_no_overwrite, fin, slot_free, "result overwritten before it was taken")
    `PCTD_ASSERT_NOW(a_sym_ok, out_valid_reg && symbol_valid_reg, status_reg == ST_OK, "bad status")

endmodule

`default_nettype wire

FILE: rtl/prefix_code_trie_decoder_top.sv
// Top level of the prefix code trie decoder: controller, datapath and ports
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------------
//  input    | in_valid / in_ready  | operation, symbol, code_bits, code_length, bit_in
//  result   | out_valid / out_ready| symbol_out, symbol_valid, status, decoded_count
//  config   | psel/penable/pwrite  | paddr, pwdata, prdata (run limit at 0x0)
//
//  Decode, clear, start and bad-length add: accept, then finish; the finish waits
//  for a free result slot. Add: accept and init, then per trie level either read
//  and load of an existing child, or make and link of a new node, then finish.
//  One item in flight; in_ready is high only in the idle state.
//  A finished item waits in the result register while out_ready is low.
//  No clearing pass after reset: the root lives in flops, other nodes are read
//  only once made.
`default_nettype none

module prefix_code_trie_decoder_top
    import pctd_pkg::*;
#(
    parameter int NODE_DEPTH = DEF_NODE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [1:0]          operation,
    input  wire logic [SYM_W-1:0]    symbol,
    input  wire logic [CODE_W-1:0]   code_bits,
    input  wire logic [LEN_W-1:0]    code_length,
    input  wire logic                bit_in,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [SYM_W-1:0]         symbol_out,
    output logic                     symbol_valid,
    output logic [STATUS_W-1:0]      status,
    output logic [COUNT_W-1:0]       decoded_count,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready
);

    cmd_t     cmd;
    dp_stat_t stat;

    assign pready = 1'b1;

    pctd_ctrl u_ctrl (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .in_valid              (in_valid),
        .in_ready_unused_guard (1'b1),
        .operation             (operation),
        .stat                  (stat),
        .in_ready              (in_ready),
        .cmd                   (cmd)
    );

    pctd_dp #(
        .NODE_DEPTH (NODE_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .operation     (operation),
        .symbol        (symbol),
        .code_bits     (code_bits),
        .code_length   (code_length),
        .bit_in        (bit_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .symbol_out    (symbol_out),
        .symbol_valid  (symbol_valid),
        .status        (status),
        .decoded_count (decoded_count),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata)
    );

endmodule

`default_nettype wire

FILE: sim/prefix_code_trie_checker.sv
// Trie decoder checker: tracks accepted items, predicts each result and compares it
`timescale 1ns / 100ps

module prefix_code_trie_checker
    import pctd_pkg::*;
#(
    parameter int NODE_DEPTH = DEF_NODE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_ready,
    input  wire logic [1:0]          operation,
    input  wire logic [SYM_W-1:0]    symbol,
    input  wire logic [CODE_W-1:0]   code_bits,
    input  wire logic [LEN_W-1:0]    code_length,
    input  wire logic                bit_in,
    input  wire logic                out_valid,
    input  wire logic                out_ready,
    input  wire logic [SYM_W-1:0]    symbol_out,
    input  wire logic                symbol_valid,
    input  wire logic [STATUS_W-1:0] status,
    input  wire logic [COUNT_W-1:0]  decoded_count,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic                pready,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output int                       errors,
    output int                       pending
);

    typedef struct packed {
        logic [SYM_W-1:0]   sym;
        logic               valid;
        status_t            st;
        logic [COUNT_W-1:0] count;
    } trie_result_t;

    int               node_left  [NODE_DEPTH];
    int               node_right [NODE_DEPTH];
    logic [SYM_W-1:0] node_sym   [NODE_DEPTH];
    int               nodes_made;
    int               walk_node;
    int               sym_count;
    int               sym_limit;
    int               mismatch_total = 0;
    int               waiting = 0;
    trie_result_t     expected_q [$];

    assign errors  = mismatch_total;
    assign pending = waiting;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t checker: %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_total++;
    endtask

    // returns 0 when the store has no free node
    function automatic int make_node(logic [SYM_W-1:0] sym);
        int n;
        if (nodes_made >= NODE_DEPTH)
            return 0;
        n = nodes_made;
        nodes_made++;
        node_left[n]  = 0;
        node_right[n] = 0;
        node_sym[n]   = sym;
        return n;
    endfunction

    function automatic status_t insert_code(logic [SYM_W-1:0] sym, logic [CODE_W-1:0] code,
                                            logic [LEN_W-1:0] len);
        int node;
        int child;
        node = 0;
        if (len == 0 || len > MAX_CODE_LEN)
            return ST_BAD_LEN;
        // inner levels: reuse what exists, make the rest with symbol 0
        for (int i = int'(len) - 1; i > 0; i--)
        begin
            child = code[i] ? node_right[node] : node_left[node];
            if (child == 0)
            begin
                child = make_node('0);
                if (child == 0)
                    return ST_FULL;
                if (code[i])
                    node_right[node] = child;
                else
                    node_left[node] = child;
            end
            node = child;
        end
        // last level always gets a fresh node, orphaning any old branch
        child = make_node(sym);
        if (child == 0)
            return ST_FULL;
        if (code[0])
            node_right[node] = child;
        else
            node_left[node] = child;
        return ST_OK;
    endfunction

    function automatic trie_result_t predict_step(op_t op, logic [SYM_W-1:0] sym,
                                                  logic [CODE_W-1:0] code,
                                                  logic [LEN_W-1:0] len, logic dir);
        trie_result_t r;
        int           child;
        r    = '0;
        r.st = ST_OK;
        case (op)
            OP_CLEAR:
            begin
                nodes_made    = 1;
                node_left[0]  = 0;
                node_right[0] = 0;
                node_sym[0]   = '0;
                walk_node     = 0;
            end
            OP_ADD:
                r.st = insert_code(sym, code, len);
            OP_START:
            begin
                sym_count = 0;
                walk_node = 0;
            end
            OP_DECODE:
            begin
                if (sym_limit != -1 && (sym_limit < 0 || sym_count >= sym_limit))
                    r.st = ST_LIMIT;
                else
                begin
                    child = dir ? node_right[walk_node] : node_left[walk_node];
                    if (child == 0)
                    begin
                        r.st      = ST_INVALID;
                        walk_node = 0;
                    end
                    else if (node_left[child] == 0 && node_right[child] == 0)
                    begin
                        r.sym   = node_sym[child];
                        r.valid = 1'b1;
                        if (sym_count < 65535)
                            sym_count++;
                        walk_node = 0;
                    end
                    else
                        walk_node = child;
                end
            end
        endcase
        r.count = sym_count[COUNT_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        trie_result_t want;
        if (!rst_n)
        begin
            nodes_made    = 1;
            node_left[0]  = 0;
            node_right[0] = 0;
            node_sym[0]   = '0;
            walk_node     = 0;
            sym_count     = 0;
            sym_limit     = -1;
            expected_q.delete();
            waiting <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == REG_RUN_LIMIT)
                sym_limit = {{15{pwdata[16]}}, pwdata[16:0]};
            if (in_valid && in_ready)
                expected_q.push_back(predict_step(op_t'(operation), symbol, code_bits,
                                                  code_length, bit_in));
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("result with nothing expected", status, '0);
                else
                begin
                    want = expected_q.pop_front();
                    if (symbol_out !== want.sym)
                        report_mismatch("symbol_out", symbol_out, want.sym);
                    if (symbol_valid !== want.valid)
                        report_mismatch("symbol_valid", symbol_valid, want.valid);
                    if (status !== want.st)
                        report_mismatch("status", status, want.st);
                    if (decoded_count !== want.count)
                        report_mismatch("decoded_count", decoded_count, want.count);
                end
            end
            waiting <= expected_q.size();
        end
    end

endmodule

FILE: sim/tb_prefix_code_trie_decoder_top.sv
// Testbench top: clock, reset, stimulus and verdict for the prefix code trie decoder
`timescale 1ns / 100ps

module tb_prefix_code_trie_decoder_top;
    import pctd_pkg::*;

    localparam int RANDOM_ITEMS = 1200;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [1:0]          operation = OP_CLEAR;
    logic [SYM_W-1:0]    symbol = '0;
    logic [CODE_W-1:0]   code_bits = '0;
    logic [LEN_W-1:0]    code_length = '0;
    logic                bit_in = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [SYM_W-1:0]    symbol_out;
    logic                symbol_valid;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  decoded_count;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = REG_RUN_LIMIT;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    int          errors;
    int          pending;
    bit          calm = 1'b0;
    int          items_sent = 0;
    int          op_seen [4] = '{default: 0};
    int          limit_writes = 0;
    logic [31:0] code_q [$];
    int          len_q  [$];

    prefix_code_trie_decoder_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .symbol        (symbol),
        .code_bits     (code_bits),
        .code_length   (code_length),
        .bit_in        (bit_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .symbol_out    (symbol_out),
        .symbol_valid  (symbol_valid),
        .status        (status),
        .decoded_count (decoded_count),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    prefix_code_trie_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .symbol        (symbol),
        .code_bits     (code_bits),
        .code_length   (code_length),
        .bit_in        (bit_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .symbol_out    (symbol_out),
        .symbol_valid  (symbol_valid),
        .status        (status),
        .decoded_count (decoded_count),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .errors        (errors),
        .pending       (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // result side: random stall bursts, none once calm
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    initial
    begin
        #10_000_000;
        $display("timeout: items or results stalled");
        $display("prefix_code_trie_decoder_top: mismatch");
        $finish;
    end

    task automatic push_item(op_t op, logic [SYM_W-1:0] sym, logic [CODE_W-1:0] code,
                             logic [LEN_W-1:0] len, logic dir);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        symbol      <= sym;
        code_bits   <= code;
        code_length <= len;
        bit_in      <= dir;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
        op_seen[int'(op)]++;
    endtask

    task automatic add_code(logic [SYM_W-1:0] sym, logic [CODE_W-1:0] code,
                            logic [LEN_W-1:0] len);
        push_item(OP_ADD, sym, code, len, 1'($urandom));
    endtask

    task automatic decode_bit(logic dir);
        push_item(OP_DECODE, 8'($urandom), 32'($urandom), 6'($urandom), dir);
    endtask

    task automatic control_item(op_t op);
        push_item(op, 8'($urandom), 32'($urandom), 6'($urandom), 1'($urandom));
    endtask

    // hold the sender until every outstanding result has been taken
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic write_limit(int value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_RUN_LIMIT;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        limit_writes++;
    endtask

    initial
    begin
        int          base;
        int          n;
        int          r;
        int          idx;
        int          len;
        bit          deep;
        logic [31:0] code;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty trie, bad lengths, leaf split, replacement, limit
        write_limit(-1);
        decode_bit(1'b0);
        add_code(8'h11, 32'($urandom), 6'd0);
        add_code(8'h22, 32'($urandom), 6'd33);
        add_code(8'h33, 32'hFFFF_FFFF, 6'd63);
        add_code(8'hA5, 32'hFFFF_FFFE, 6'd1);
        add_code(8'h3C, 32'h0000_0002, 6'd2);
        add_code(8'hFF, 32'hFFFF_FFFF, 6'd32);
        add_code(8'h00, 32'h8000_0000, 6'd32);   // walks through the leaf at 10
        decode_bit(1'b0);
        decode_bit(1'b1);
        add_code(8'h5A, 32'h0000_0003, 6'd2);    // mid-code, replaces branch 11
        decode_bit(1'b1);
        write_limit(1);
        decode_bit(1'b0);
        write_limit(-1);
        decode_bit(1'b1);
        decode_bit(1'b0);
        decode_bit(1'b1);
        decode_bit(1'b0);
        control_item(OP_START);
        control_item(OP_CLEAR);
        decode_bit(1'b1);

        // limit at its extremes
        calm = 1'b1;
        control_item(OP_CLEAR);
        add_code(8'h77, 32'($urandom) & 32'hFFFF_FFFE, 6'd1);
        control_item(OP_START);
        write_limit(65535);
        decode_bit(1'b0);
        write_limit(-65536);
        decode_bit(1'b0);
        write_limit(0);
        control_item(OP_START);
        decode_bit(1'b0);
        write_limit(-1);
        calm = 1'b0;

        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS)
        begin
            calm = (items_sent - base) > RANDOM_ITEMS - 200;
            if ($urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: write_limit(-1);
                    4, 5:       write_limit($urandom_range(1, 25));
                    6:          write_limit(0);
                    7:          write_limit(-65536);
                    8:          write_limit(65535);
                    default:    write_limit(-int'($urandom_range(1, 65535)));
                endcase
            end
            if ($urandom_range(0, 3) != 0)
            begin
                control_item(OP_CLEAR);
                code_q.delete();
                len_q.delete();
            end
            if ($urandom_range(0, 1) == 1)
                control_item(OP_START);

            // deep rounds use long codes to run the node store out
            deep = ($urandom_range(0, 5) == 0);
            n = deep ? $urandom_range(18, 26) : $urandom_range(1, 10);
            repeat (n)
            begin
                r = $urandom_range(0, 19);
                if (deep)
                    len = (r == 0) ? $urandom_range(33, 63) : $urandom_range(24, 32);
                else if (r < 14)
                    len = $urandom_range(1, 6);
                else if (r < 18)
                    len = $urandom_range(7, 32);
                else
                    len = (r == 18) ? 0 : $urandom_range(33, 63);
                code = $urandom;
                add_code(8'($urandom), code, 6'(len));
                if (len >= 1 && len <= MAX_CODE_LEN)
                begin
                    code_q.push_back(code);
                    len_q.push_back(len);
                end
            end

            n = deep ? $urandom_range(2, 5) : $urandom_range(4, 24);
            repeat (n)
            begin
                r = $urandom_range(0, 19);
                if (r < 16 && code_q.size() > 0)
                begin
                    idx = $urandom_range(0, code_q.size() - 1);
                    for (int i = len_q[idx] - 1; i >= 0; i--)
                        decode_bit(code_q[idx][i]);
                end
                else if (r < 18)
                    repeat ($urandom_range(1, 4)) decode_bit(1'($urandom));
                else if (r == 18)
                begin
                    code = $urandom;
                    len = $urandom_range(1, 6);
                    add_code(8'($urandom), code, 6'(len));
                    code_q.push_back(code);
                    len_q.push_back(len);
                end
                else
                    control_item(OP_START);
            end
        end

        settle();
        repeat (120) @(posedge clk);
        $display("covered %0d items: %0d clears, %0d adds, %0d decode bits, %0d starts",
                 items_sent, op_seen[int'(OP_CLEAR)], op_seen[int'(OP_ADD)],
                 op_seen[int'(OP_DECODE)], op_seen[int'(OP_START)]);
        $display("run limit written %0d times, both extremes included", limit_writes);
        if (errors == 0)
            $display("prefix_code_trie_decoder_top: match");
        else
            $display("prefix_code_trie_decoder_top: mismatch");
        $finish;
    end

endmodule

FILE: prefix_code_trie_decoder_top.f
+incdir+rtl
rtl/pctd_pkg.sv
rtl/pctd_ram.sv
rtl/pctd_ctrl.sv
rtl/pctd_dp.sv
rtl/prefix_code_trie_decoder_top.sv
sim/prefix_code_trie_checker.sv
sim/tb_prefix_code_trie_decoder_top.sv
